// File: sv/tla_pkg.sv
// Shared definitions for the toroidal life automaton: action codes, register
// indexes, configuration defaults, the row compare status and the B3/S23 rule.
// No dependencies.
package tla_pkg;

  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_EVOLVE  = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  typedef struct packed {
    logic eq_last;
    logic eq_earl;
  } row_cmp_t;

  // B3/S23: born with 3 neighbors, survive with 2 or 3
  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    life_rule = (count == 4'd3) || (alive && (count == 4'd2));
  endfunction

endpackage

// File: sv/tla_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on an address collision. No dependencies.
module tla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tla_row_step.sv
// One row of the next generation from three wrapped rows, plus compares of
// the new row against the two recorded generations. Depends on tla_pkg.
module tla_row_step #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [MAX_WIDTH-1:0]                 prev_row,
  input  logic [MAX_WIDTH-1:0]                 cur_row,
  input  logic [MAX_WIDTH-1:0]                 next_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       width,
  input  logic [MAX_WIDTH-1:0]                 last_row,
  input  logic [MAX_WIDTH-1:0]                 earl_row,
  output logic [MAX_WIDTH-1:0]                 new_row,
  output tla_pkg::row_cmp_t                    cmp
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CIW-1:0] edge_idx;
  logic           p_edge, c_edge, n_edge;
  logic [MAX_WIDTH-1:0] miss_last, miss_earl;

  assign edge_idx = CIW'(width - WW'(1));
  assign p_edge = prev_row[edge_idx];
  assign c_edge = cur_row[edge_idx];
  assign n_edge = next_row[edge_idx];

  always_comb begin
    logic pl, pr, cl, cr, nl, nr, in_use;
    logic [3:0] cnt;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      in_use = WW'(c) < width;
      if (c == 0) begin
        pl = p_edge; cl = c_edge; nl = n_edge;
      end else begin
        pl = prev_row[c-1]; cl = cur_row[c-1]; nl = next_row[c-1];
      end
      if (WW'(c) == width - WW'(1)) begin
        pr = prev_row[0]; cr = cur_row[0]; nr = next_row[0];
      end else if (c < MAX_WIDTH - 1) begin
        pr = prev_row[(c+1) % MAX_WIDTH];
        cr = cur_row[(c+1) % MAX_WIDTH];
        nr = next_row[(c+1) % MAX_WIDTH];
      end else begin
        pr = 1'b0; cr = 1'b0; nr = 1'b0;
      end
      cnt = 4'(pl) + 4'(prev_row[c]) + 4'(pr) + 4'(cl) + 4'(cr)
          + 4'(nl) + 4'(next_row[c]) + 4'(nr);
      new_row[c]   = in_use ? tla_pkg::life_rule(cur_row[c], cnt) : cur_row[c];
      miss_last[c] = in_use && (new_row[c] != last_row[c]);
      miss_earl[c] = in_use && (new_row[c] != earl_row[c]);
    end
  end

  assign cmp.eq_last = ~|miss_last;
  assign cmp.eq_earl = ~|miss_earl;

endmodule

// File: sv/toroidal_life_automaton_top.sv
// Toroidal Game of Life (B3/S23) engine, top level.
// Depends on tla_pkg, tla_ram and tla_row_step.
//
// Usage:
//   Input channel: present in_action/in_col/in_row/in_cell_value with start;
//   a transaction is taken at a rising edge with start high and busy low.
//   Result channel: out_valid strobes for exactly one cycle with out_cell_out
//   and out_stable. The receiver cannot stall; every result must be taken.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 width, 1 height)
//   and cfg_data; cfg_ready is always high. Write only while idle.
// Operation:
//   Cell read and write give their result in the cycle after they are taken and
//   run one per cycle while busy is low; the live grid row is read, modified
//   and written back, with forwarding of the previous cycle's write.
//   Evolve streams the live rows through a three-row window while busy is
//   high; the result is strobed in the first cycle with busy low. The row pass
//   goes over the single read port of each row memory.
//   Restart copies the live grid into the newest generation while busy is
//   high; the result is strobed in the first cycle with busy low.
// Reset: rst_n low clears control state; afterwards a clearing pass over the
//   MAX_HEIGHT rows zeroes all three row memories while busy is high.
module toroidal_life_automaton_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [5:0]                    in_col,
  input  logic [5:0]                    in_row,
  input  logic                          in_cell_value,
  output logic                          out_valid,
  output logic                          out_cell_out,
  output logic                          out_stable,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tla_pkg::CFG_W-1:0]     cfg_data
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int KW  = $clog2(MAX_HEIGHT + 3);
  localparam int SWW = (WW > tla_pkg::CFG_W) ? WW : tla_pkg::CFG_W;
  localparam int SHW = (HW > tla_pkg::CFG_W) ? HW : tla_pkg::CFG_W;

  localparam logic [1:0] ST_CLR   = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVO   = 2'd2;
  localparam logic [1:0] ST_RSTRT = 2'd3;

  localparam logic [KW-1:0] EVO_LAST = KW'(MAX_HEIGHT + 1);
  localparam logic [KW-1:0] ROW_LAST = KW'(MAX_HEIGHT - 1);

  logic [1:0]              state_r;
  logic [KW-1:0]           cnt_r, k1_r;
  logic                    v1_r;
  logic [MAX_WIDTH-1:0]    prev_r, cur_r, row0_r;
  logic                    eq_last_r, eq_earl_r;
  logic [1:0]              depth_r;
  logic                    stable_r, done_r;
  logic                    s1_v_r, s1_rd_r, s1_wr_r, s1_val_r;
  logic [AW-1:0]           s1_addr_r;
  logic [CIW-1:0]          s1_col_r;
  logic                    fwd_v_r;
  logic [AW-1:0]           fwd_addr_r;
  logic [MAX_WIDTH-1:0]    fwd_data_r;
  logic [tla_pkg::CFG_W-1:0] gw_r, gh_r;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [KW-1:0] h_k;
  logic          accept, in_range, issue, stage_calc, row_lt_h, evo_final, rst_final;
  logic [KW-1:0] row_k;

  logic                 live_we, last_we, earl_we;
  logic [AW-1:0]        live_wa, last_wa, earl_wa, live_ra, hist_ra;
  logic [MAX_WIDTH-1:0] live_wd, last_wd, earl_wd, live_rd, last_rd, earl_rd;
  logic [MAX_WIDTH-1:0] s1_row, s1_mod, step_next, step_new, new_full;
  tla_pkg::row_cmp_t    cmp;
  logic                 eq_last_nxt, eq_earl_nxt;

  // Saturate the size registers into 1..MAX
  always_comb begin
    logic [SWW-1:0] wx;
    logic [SHW-1:0] hx;
    wx = SWW'(gw_r);
    hx = SHW'(gh_r);
    if (wx == '0) eff_w = WW'(1);
    else if (wx > SWW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(wx);
    if (hx == '0) eff_h = HW'(1);
    else if (hx > SHW'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(hx);
  end

  assign h_k       = KW'(eff_h);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_range  = (SWW'(in_col) < SWW'(eff_w)) && (SHW'(in_row) < SHW'(eff_h));

  // Evolve issue side: live read order is h-1, 0, 1, ..., h-1, then h-1 again and rows h.. direct
  assign issue = ((state_r == ST_EVO) && (cnt_r <= EVO_LAST)) ||
                 ((state_r == ST_RSTRT) && (cnt_r <= ROW_LAST));

  always_comb begin
    live_ra = AW'(in_row);
    hist_ra = AW'(cnt_r - KW'(2));
    case (state_r)
      ST_EVO: begin
        if (cnt_r == '0) live_ra = AW'(eff_h - HW'(1));
        else if (cnt_r <= h_k) live_ra = AW'(cnt_r - KW'(1));
        else live_ra = AW'(cnt_r - KW'(2));
      end
      ST_RSTRT: live_ra = AW'(cnt_r);
      default:  live_ra = AW'(in_row);
    endcase
  end

  // Evolve compute side: row k1-2 is finished when its next row arrives
  assign row_k      = k1_r - KW'(2);
  assign stage_calc = (state_r == ST_EVO) && v1_r && (k1_r >= KW'(2));
  assign row_lt_h   = row_k < h_k;
  assign evo_final  = (state_r == ST_EVO) && v1_r && (k1_r == EVO_LAST);
  assign rst_final  = (state_r == ST_RSTRT) && v1_r && (k1_r == ROW_LAST);
  assign step_next  = (k1_r == h_k + KW'(1)) ? row0_r : live_rd;

  tla_row_step #(.MAX_WIDTH(MAX_WIDTH)) u_step (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (step_next),
    .width    (eff_w),
    .last_row (last_rd),
    .earl_row (earl_rd),
    .new_row  (step_new),
    .cmp      (cmp)
  );

  assign new_full    = row_lt_h ? step_new : live_rd;
  assign eq_last_nxt = eq_last_r && (!row_lt_h || cmp.eq_last);
  assign eq_earl_nxt = eq_earl_r && (!row_lt_h || cmp.eq_earl);

  // Cell access: forward the previous cycle's write to the same row
  assign s1_row = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : live_rd;
  always_comb begin
    s1_mod = s1_row;
    s1_mod[s1_col_r] = s1_val_r;
  end

  // Write port selection for the three row memories
  always_comb begin
    live_we = 1'b0; live_wa = AW'(cnt_r); live_wd = '0;
    last_we = 1'b0; last_wa = AW'(cnt_r); last_wd = '0;
    earl_we = 1'b0; earl_wa = AW'(cnt_r); earl_wd = '0;
    case (state_r)
      ST_CLR: begin
        live_we = 1'b1;
        last_we = 1'b1;
        earl_we = 1'b1;
      end
      ST_IDLE: begin
        live_we = s1_v_r && s1_wr_r;
        live_wa = s1_addr_r;
        live_wd = s1_mod;
      end
      ST_EVO: begin
        live_we = stage_calc && row_lt_h;
        live_wa = AW'(row_k);
        live_wd = step_new;
        last_we = stage_calc;
        last_wa = AW'(row_k);
        last_wd = new_full;
        earl_we = stage_calc;
        earl_wa = AW'(row_k);
        earl_wd = last_rd;
      end
      ST_RSTRT: begin
        last_we = v1_r;
        last_wa = AW'(k1_r);
        last_wd = live_rd;
      end
      default: begin
        live_we = 1'b0;
      end
    endcase
  end

  tla_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_live (
    .clk(clk), .we(live_we), .waddr(live_wa), .wdata(live_wd),
    .raddr(live_ra), .rdata(live_rd)
  );
  tla_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_last (
    .clk(clk), .we(last_we), .waddr(last_wa), .wdata(last_wd),
    .raddr(hist_ra), .rdata(last_rd)
  );
  tla_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_earl (
    .clk(clk), .we(earl_we), .waddr(earl_wa), .wdata(earl_wd),
    .raddr(hist_ra), .rdata(earl_rd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= tla_pkg::CFG_SIZE_RESET;
      gh_r <= tla_pkg::CFG_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tla_pkg::REG_GRID_WIDTH:  gw_r <= cfg_data;
        tla_pkg::REG_GRID_HEIGHT: gh_r <= cfg_data;
        default: gw_r <= gw_r;
      endcase
    end
  end

  // Sequencer and history control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      cnt_r     <= '0;
      v1_r      <= 1'b0;
      depth_r   <= 2'd0;
      stable_r  <= 1'b0;
      done_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      fwd_v_r   <= 1'b0;
      eq_last_r <= 1'b1;
      eq_earl_r <= 1'b1;
    end else begin
      done_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      v1_r    <= issue;
      fwd_v_r <= live_we && (state_r == ST_IDLE);
      case (state_r)
        ST_CLR: begin
          cnt_r <= cnt_r + KW'(1);
          if (cnt_r == ROW_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            case (in_action)
              tla_pkg::ACT_EVOLVE: begin
                state_r   <= ST_EVO;
                eq_last_r <= 1'b1;
                eq_earl_r <= 1'b1;
              end
              tla_pkg::ACT_RESTART: begin
                state_r  <= ST_RSTRT;
                depth_r  <= 2'd0;
                stable_r <= 1'b0;
              end
              default: begin
                s1_v_r <= 1'b1;
              end
            endcase
          end
        end
        ST_EVO: begin
          if (issue) begin
            cnt_r <= cnt_r + KW'(1);
          end
          if (stage_calc) begin
            eq_last_r <= eq_last_nxt;
            eq_earl_r <= eq_earl_nxt;
          end
          if (evo_final) begin
            stable_r <= (depth_r != 2'd0) && (eq_last_nxt || eq_earl_nxt);
            if (depth_r != 2'd2) depth_r <= depth_r + 2'd1;
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        ST_RSTRT: begin
          if (issue) begin
            cnt_r <= cnt_r + KW'(1);
          end
          if (rst_final) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: window, cell stage, forwarding
  always_ff @(posedge clk) begin
    k1_r <= cnt_r;
    if ((state_r == ST_EVO) && v1_r && (k1_r <= h_k)) begin
      prev_r <= cur_r;
      cur_r  <= live_rd;
      if (k1_r == KW'(1)) row0_r <= live_rd;
    end
    s1_rd_r    <= (in_action == tla_pkg::ACT_READ) && in_range;
    s1_wr_r    <= (in_action == tla_pkg::ACT_WRITE) && in_range;
    s1_addr_r  <= AW'(in_row);
    s1_col_r   <= CIW'(in_col);
    s1_val_r   <= in_cell_value;
    fwd_addr_r <= live_wa;
    fwd_data_r <= live_wd;
  end

  assign out_valid    = s1_v_r || done_r;
  assign out_cell_out = s1_v_r && s1_rd_r && s1_row[s1_col_r];
  assign out_stable   = stable_r;

  // Cell stage never overlaps a grid pass
  a_s1_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !s1_v_r)
    else $error("cell stage active during grid pass");

  // One result source at a time
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !s1_v_r)
    else $error("two results in one cycle");

  // Evolve writes the live grid only inside the rows in use
  a_evo_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (live_we && (state_r == ST_EVO)) |-> (KW'(live_wa) < h_k))
    else $error("evolve wrote live row outside grid");

  // A pass result follows the return to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == ST_EVO || $past(state_r) == ST_RSTRT))
    else $error("pass result without a pass");

endmodule
